### rtl/mht_pkg.sv
// Shared types, constants and codes for the MAC hash table.
package mht_pkg;

    // Table geometry. BUCKETS must be a power of two.
    localparam int BUCKETS     = 64;
    localparam int BUCKET_W    = $clog2(BUCKETS);
    localparam int MAX_ENTRIES = 32;
    localparam int ID_W        = 5;
    localparam int MAC_W       = 48;
    localparam int OWNER_W     = 32;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    // FNV-1a hash constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Operation codes.
    localparam logic [1:0] MODE_INSERT    = 2'd0;
    localparam logic [1:0] MODE_LOOKUP_MAC = 2'd1;
    localparam logic [1:0] MODE_LOOKUP_ID = 2'd2;
    localparam logic [1:0] MODE_DELETE    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [MAC_W-1:0]   mac;
        logic [ID_W-1:0]    ident;
        logic [OWNER_W-1:0] owner;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    found_ident;
        logic [MAC_W-1:0]   found_mac;
        logic [OWNER_W-1:0] found_owner;
    } t_out;

    // One bucket entry as kept in the bucket memory.
    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [ID_W-1:0]    ident;
        logic [OWNER_W-1:0] owner;
    } t_entry;

endpackage

### rtl/mht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/mac_hash_table_with_id_slots.sv
// Top level: MAC hash table with FNV-1a hashing, linear probing and ID slots.
// Insert and lookup by MAC: hash the six key bytes, then probe buckets until the key is
// found, an empty bucket ends the search or a full sweep is done. Lookup by ID reads the
// bucket that the ID maps to. Delete: read by ID, then re-hash and re-place each chain entry,
// passing over occupied buckets while placing it. One transaction is in work at a time; the
// bucket memory read-modify-write loop sets the rate. Reset is synchronous and clears valid
// bits, the ID mask and the count, with no clearing pass.
module mac_hash_table_with_id_slots (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mht_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mht_pkg::t_out o_out_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_HASH   = 9'b000000010,
        S_PROBE  = 9'b000000100,
        S_PCMP   = 9'b000001000,
        S_BYID   = 9'b000010000,
        S_DCHK   = 9'b000100000,
        S_DRD    = 9'b001000000,
        S_DPLACE = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    localparam int PCNT_W = mht_pkg::BUCKET_W + 1;

    t_state                          r_state, n_state;
    mht_pkg::t_in                    r_in, n_in;
    mht_pkg::t_out                   r_res, n_res;
    mht_pkg::t_out                   r_out, n_out;
    logic                            r_out_valid, n_out_valid;
    logic [mht_pkg::BUCKETS-1:0]     r_bvalid, n_bvalid;
    logic [mht_pkg::MAX_ENTRIES-1:0] r_ids, n_ids;
    logic [mht_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [mht_pkg::BUCKET_W-1:0]    r_map [mht_pkg::MAX_ENTRIES];
    logic [mht_pkg::BUCKET_W-1:0]    n_map [mht_pkg::MAX_ENTRIES];
    logic [mht_pkg::MAC_W-1:0]       r_hkey, n_hkey;
    logic [31:0]                     r_hash, n_hash;
    logic [2:0]                      r_hcnt, n_hcnt;
    logic [mht_pkg::BUCKET_W-1:0]    r_pos, n_pos;
    logic [PCNT_W-1:0]               r_pcnt, n_pcnt;
    logic [mht_pkg::BUCKET_W-1:0]    r_bpos, n_bpos;
    logic [mht_pkg::BUCKET_W-1:0]    r_nxt, n_nxt;
    logic [PCNT_W-1:0]               r_steps, n_steps;
    mht_pkg::t_entry                 r_ent, n_ent;

    logic                            ram_we;
    logic [mht_pkg::BUCKET_W-1:0]    ram_waddr;
    mht_pkg::t_entry                 ram_wdata;
    logic [mht_pkg::BUCKET_W-1:0]    ram_raddr;
    mht_pkg::t_entry                 ram_rdata;

    logic                            free_found;
    logic [mht_pkg::ID_W-1:0]        free_id;
    logic [31:0]                     hash_x;
    logic [31:0]                     hash_mul;
    logic                            out_take;
    logic                            id_ok;

    // Bucket store: key, ID and owner per bucket.
    mht_ram #(
        .WIDTH($bits(mht_pkg::t_entry)),
        .DEPTH(mht_pkg::BUCKETS)
    ) u_bucket_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Lowest free ID.
    always_comb begin
        free_found = 1'b0;
        free_id    = '0;
        for (int k = mht_pkg::MAX_ENTRIES - 1; k >= 0; k--) begin
            if (!r_ids[k]) begin
                free_found = 1'b1;
                free_id    = mht_pkg::ID_W'(k);
            end
        end
    end

    // One FNV-1a byte step per cycle.
    assign hash_x   = r_hash ^ {24'd0, r_hkey[{r_hcnt, 3'b000} +: 8]};
    assign hash_mul = hash_x * mht_pkg::FNV_PRIME;

    assign out_take = r_out_valid && i_out_ready;
    assign id_ok    = (32'(i_in_data.ident) < mht_pkg::MAX_ENTRIES) &&
                      r_ids[i_in_data.ident];

    // Bucket memory read address follows the state.
    always_comb begin
        case (r_state)
            S_IDLE:  ram_raddr = r_map[i_in_data.ident];
            S_DCHK:  ram_raddr = r_nxt;
            default: ram_raddr = r_pos;
        endcase
    end

    // Next-state and datapath logic.
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_bvalid    = r_bvalid;
        n_ids       = r_ids;
        n_count     = r_count;
        n_map       = r_map;
        n_hkey      = r_hkey;
        n_hash      = r_hash;
        n_hcnt      = r_hcnt;
        n_pos       = r_pos;
        n_pcnt      = r_pcnt;
        n_bpos      = r_bpos;
        n_nxt       = r_nxt;
        n_steps     = r_steps;
        n_ent       = r_ent;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = '{mac: r_in.mac, ident: free_id, owner: r_in.owner};

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // Take a new transaction.
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in   = i_in_data;
                    n_hkey = i_in_data.mac;
                    n_hash = mht_pkg::FNV_BASIS;
                    n_hcnt = '0;
                    if (i_in_data.mode == mht_pkg::MODE_INSERT ||
                        i_in_data.mode == mht_pkg::MODE_LOOKUP_MAC) begin
                        n_state = S_HASH;
                    end else if (id_ok) begin
                        n_bpos  = r_map[i_in_data.ident];
                        n_state = S_BYID;
                    end else begin
                        n_res   = '{status: mht_pkg::ST_NOTFOUND, default: '0};
                        n_state = S_DONE;
                    end
                end
            end

            // Hash the key, then probe or re-place.
            S_HASH: begin
                n_hash = hash_mul;
                n_hcnt = r_hcnt + 3'd1;
                if (r_hcnt == 3'd5) begin
                    n_pos   = hash_mul[mht_pkg::BUCKET_W-1:0];
                    n_pcnt  = '0;
                    n_state = (r_in.mode == mht_pkg::MODE_DELETE) ? S_DPLACE : S_PROBE;
                end
            end

            // Probe: an empty bucket or a full sweep ends the search.
            S_PROBE: begin
                if (r_pcnt == PCNT_W'(mht_pkg::BUCKETS) || !r_bvalid[r_pos]) begin
                    n_state = S_DONE;
                    if (r_in.mode == mht_pkg::MODE_LOOKUP_MAC) begin
                        n_res = '{status: mht_pkg::ST_NOTFOUND, default: '0};
                    end else if (32'(r_count) >= mht_pkg::MAX_ENTRIES || !free_found ||
                                 r_pcnt == PCNT_W'(mht_pkg::BUCKETS)) begin
                        n_res = '{status: mht_pkg::ST_FULL, default: '0};
                    end else begin
                        ram_we            = 1'b1;
                        n_bvalid[r_pos]   = 1'b1;
                        n_map[free_id]    = r_pos;
                        n_ids[free_id]    = 1'b1;
                        n_count           = r_count + 1'b1;
                        n_res = '{status: mht_pkg::ST_DONE, found_ident: free_id,
                                  found_mac: r_in.mac, found_owner: r_in.owner};
                    end
                end else begin
                    n_state = S_PCMP;
                end
            end

            // Compare the key read from the probed bucket.
            S_PCMP: begin
                if (ram_rdata.mac == r_in.mac) begin
                    n_res = '{status: (r_in.mode == mht_pkg::MODE_INSERT) ?
                                      mht_pkg::ST_EXISTS : mht_pkg::ST_DONE,
                              found_ident: ram_rdata.ident, found_mac: ram_rdata.mac,
                              found_owner: ram_rdata.owner};
                    n_state = S_DONE;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_pcnt  = r_pcnt + 1'b1;
                    n_state = S_PROBE;
                end
            end

            // Entry by ID is read; report it and start a delete if asked.
            S_BYID: begin
                n_res = '{status: mht_pkg::ST_DONE, found_ident: r_in.ident,
                          found_mac: ram_rdata.mac, found_owner: ram_rdata.owner};
                if (r_in.mode == mht_pkg::MODE_LOOKUP_ID) begin
                    n_state = S_DONE;
                end else begin
                    n_bvalid[r_bpos]  = 1'b0;
                    n_ids[r_in.ident] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_nxt   = r_bpos + 1'b1;
                    n_steps = '0;
                    n_state = S_DCHK;
                end
            end

            // Chain walk: stop at an empty bucket or after the step bound.
            S_DCHK: begin
                if (r_steps == PCNT_W'(mht_pkg::BUCKETS - 1) || !r_bvalid[r_nxt]) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DRD;
                end
            end

            // Pull the chain entry out and hash its key.
            S_DRD: begin
                n_ent           = ram_rdata;
                n_bvalid[r_nxt] = 1'b0;
                n_hkey          = ram_rdata.mac;
                n_hash          = mht_pkg::FNV_BASIS;
                n_hcnt          = '0;
                n_state         = S_HASH;
            end

            // Re-place the entry at the first empty bucket from its home.
            S_DPLACE: begin
                if (!r_bvalid[r_pos]) begin
                    ram_we          = 1'b1;
                    ram_wdata       = r_ent;
                    n_bvalid[r_pos] = 1'b1;
                    if (32'(r_ent.ident) < mht_pkg::MAX_ENTRIES) begin
                        n_map[r_ent.ident] = r_pos;
                    end
                    n_nxt   = r_nxt + 1'b1;
                    n_steps = r_steps + 1'b1;
                    n_state = S_DCHK;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || out_take) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bvalid    <= '0;
            r_ids       <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bvalid    <= n_bvalid;
            r_ids       <= n_ids;
            r_count     <= n_count;
        end
        r_in    <= n_in;
        r_res   <= n_res;
        r_out   <= n_out;
        r_map   <= n_map;
        r_hkey  <= n_hkey;
        r_hash  <= n_hash;
        r_hcnt  <= n_hcnt;
        r_pos   <= n_pos;
        r_pcnt  <= n_pcnt;
        r_bpos  <= n_bpos;
        r_nxt   <= n_nxt;
        r_steps <= n_steps;
        r_ent   <= n_ent;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/mht_checker.sv
// Port-level checker for the MAC hash table, bound to the top level.
module mht_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input mht_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input mht_pkg::t_out o_out_data
);

    // A result that is not taken holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // Not-found and full results carry zero fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == mht_pkg::ST_NOTFOUND ||
                        o_out_data.status == mht_pkg::ST_FULL)
        |-> o_out_data.found_ident == '0 && o_out_data.found_mac == '0 &&
            o_out_data.found_owner == '0)
        else $error("fields not zero on not-found or full result");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // One transaction at a time: ready drops after an accepted input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous transaction in work");

endmodule

bind mac_hash_table_with_id_slots mht_checker u_mht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

### tb/sv/tb_top.sv
// Testbench for the MAC hash table: directed table plus random traffic against a predictor.
`timescale 1ns / 1ps

module tb_top;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    mht_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    mht_pkg::t_out o_out_data;

    mac_hash_table_with_id_slots DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock with a 12 ns period.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Predictor copy of the table state.
    logic                        tbl_valid [mht_pkg::BUCKETS];
    logic [mht_pkg::MAC_W-1:0]   tbl_mac   [mht_pkg::BUCKETS];
    logic [mht_pkg::ID_W-1:0]    tbl_id    [mht_pkg::BUCKETS];
    logic [mht_pkg::OWNER_W-1:0] tbl_owner [mht_pkg::BUCKETS];
    logic [31:0]                 id_mask;
    logic [mht_pkg::BUCKET_W-1:0] id_slot  [mht_pkg::MAX_ENTRIES];
    int                          live_count;

    // Expected results, oldest first.
    mht_pkg::t_out expected_results[$];
    int   mismatches;
    bit   timed_out;
    bit   rx_hold;       // long receiver hold-off request
    bit   quiet_phase;   // no idling near the end
    bit   stim_done;

    // Directed rows; a row with check set carries a typed-in expected result.
    typedef struct {
        mht_pkg::t_in  item;
        bit            check;
        mht_pkg::t_out want;
    } t_row;
    t_row dir_rows[$];

    // MACs that have been inserted, for reuse by random traffic.
    logic [mht_pkg::MAC_W-1:0] seen_macs[$];

    function automatic logic [mht_pkg::BUCKET_W-1:0] fnv_bucket(
        logic [mht_pkg::MAC_W-1:0] key);
        logic [31:0] h;
        h = mht_pkg::FNV_BASIS;
        for (int i = 0; i < 6; i++) begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * mht_pkg::FNV_PRIME;
        end
        return h[mht_pkg::BUCKET_W-1:0];
    endfunction

    function automatic mht_pkg::t_out make_out(logic [1:0] st,
                                               logic [mht_pkg::ID_W-1:0] id,
                                               logic [mht_pkg::MAC_W-1:0] m,
                                               logic [mht_pkg::OWNER_W-1:0] o);
        mht_pkg::t_out r;
        r.status      = st;
        r.found_ident = id;
        r.found_mac   = m;
        r.found_owner = o;
        return r;
    endfunction

    // Apply one transaction to the predictor and return its result.
    function automatic mht_pkg::t_out predict_table_op(mht_pkg::t_in x);
        logic [mht_pkg::BUCKET_W-1:0] home, b, nxt, nb;
        logic [mht_pkg::MAC_W-1:0]    k2;
        logic [mht_pkg::ID_W-1:0]     id2;
        logic [mht_pkg::OWNER_W-1:0]  o2;
        int                           newid;
        home = fnv_bucket(x.mac);
        if (x.mode == mht_pkg::MODE_INSERT || x.mode == mht_pkg::MODE_LOOKUP_MAC) begin
            // Probe for the key along its chain.
            for (int i = 0; i < mht_pkg::BUCKETS; i++) begin
                b = home + i[mht_pkg::BUCKET_W-1:0];
                if (!tbl_valid[b]) break;
                if (tbl_mac[b] == x.mac)
                    return make_out(x.mode == mht_pkg::MODE_INSERT ?
                                    mht_pkg::ST_EXISTS : mht_pkg::ST_DONE,
                                    tbl_id[b], x.mac, tbl_owner[b]);
            end
            if (x.mode == mht_pkg::MODE_LOOKUP_MAC)
                return make_out(mht_pkg::ST_NOTFOUND, '0, '0, '0);
            if (live_count >= mht_pkg::MAX_ENTRIES)
                return make_out(mht_pkg::ST_FULL, '0, '0, '0);
            newid = -1;
            for (int i = 0; i < mht_pkg::MAX_ENTRIES; i++)
                if (!id_mask[i] && newid < 0) newid = i;
            if (newid < 0) return make_out(mht_pkg::ST_FULL, '0, '0, '0);
            for (int i = 0; i < mht_pkg::BUCKETS; i++) begin
                b = home + i[mht_pkg::BUCKET_W-1:0];
                if (!tbl_valid[b]) begin
                    tbl_valid[b] = 1'b1;
                    tbl_mac[b]   = x.mac;
                    tbl_id[b]    = newid[mht_pkg::ID_W-1:0];
                    tbl_owner[b] = x.owner;
                    id_slot[newid] = b;
                    id_mask[newid] = 1'b1;
                    live_count++;
                    return make_out(mht_pkg::ST_DONE, newid[mht_pkg::ID_W-1:0],
                                    x.mac, x.owner);
                end
            end
            return make_out(mht_pkg::ST_FULL, '0, '0, '0);
        end
        // By ID.
        if (x.ident >= mht_pkg::MAX_ENTRIES || !id_mask[x.ident])
            return make_out(mht_pkg::ST_NOTFOUND, '0, '0, '0);
        b = id_slot[x.ident];
        predict_table_op = make_out(mht_pkg::ST_DONE, x.ident, tbl_mac[b], tbl_owner[b]);
        if (x.mode == mht_pkg::MODE_LOOKUP_ID) return predict_table_op;
        // Delete, then re-place the rest of the chain.
        tbl_valid[b] = 1'b0;
        nxt = b + 1'b1;
        for (int s = 0; s < mht_pkg::BUCKETS - 1; s++) begin
            if (!tbl_valid[nxt]) break;
            k2  = tbl_mac[nxt];
            id2 = tbl_id[nxt];
            o2  = tbl_owner[nxt];
            tbl_valid[nxt] = 1'b0;
            home = fnv_bucket(k2);
            nb = home;
            for (int i = 0; i < mht_pkg::BUCKETS; i++) begin
                if (!tbl_valid[home + i[mht_pkg::BUCKET_W-1:0]]) begin
                    nb = home + i[mht_pkg::BUCKET_W-1:0];
                    break;
                end
            end
            tbl_valid[nb] = 1'b1;
            tbl_mac[nb]   = k2;
            tbl_id[nb]    = id2;
            tbl_owner[nb] = o2;
            if (id2 < mht_pkg::MAX_ENTRIES) id_slot[id2] = nb;
            nxt = nxt + 1'b1;
        end
        id_mask[x.ident] = 1'b0;
        if (live_count > 0) live_count--;
        return predict_table_op;
    endfunction

    function automatic mht_pkg::t_in make_in(logic [1:0] m, logic [mht_pkg::MAC_W-1:0] k,
                                             logic [mht_pkg::ID_W-1:0] id,
                                             logic [mht_pkg::OWNER_W-1:0] o);
        mht_pkg::t_in r;
        r.mode = m; r.mac = k; r.ident = id; r.owner = o;
        return r;
    endfunction

    function automatic logic [mht_pkg::MAC_W-1:0] rand_mac();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[mht_pkg::MAC_W-1:0];
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send_item(mht_pkg::t_in x, bit check, mht_pkg::t_out want);
        mht_pkg::t_out got;
        i_in_data  <= x;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = predict_table_op(x);
        if (check && got != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Directed row disagrees with predictor: typed %h, predicted %h",
                         want, got);
        end
        expected_results.push_back(got);
        if (x.mode == mht_pkg::MODE_INSERT && got.status == mht_pkg::ST_DONE)
            seen_macs.push_back(x.mac);
        // Random idle burst on the input side.
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Random transaction, mostly well-formed with keys that already exist.
    function automatic mht_pkg::t_in rand_item();
        logic [1:0]                m;
        logic [mht_pkg::MAC_W-1:0] k;
        int                        r;
        r = $urandom_range(0, 99);
        if (r < 40)      m = mht_pkg::MODE_INSERT;
        else if (r < 60) m = mht_pkg::MODE_LOOKUP_MAC;
        else if (r < 75) m = mht_pkg::MODE_LOOKUP_ID;
        else             m = mht_pkg::MODE_DELETE;
        if (seen_macs.size() != 0 && $urandom_range(0, 2) != 0)
            k = seen_macs[$urandom_range(0, seen_macs.size() - 1)];
        else
            k = rand_mac();
        return make_in(m, k, mht_pkg::ID_W'($urandom_range(0, 31)), $urandom());
    endfunction

    // Stimulus.
    initial begin
        mht_pkg::t_in  x;
        mht_pkg::t_out none;
        none = make_out(mht_pkg::ST_NOTFOUND, '0, '0, '0);
        for (int i = 0; i < mht_pkg::BUCKETS; i++) tbl_valid[i] = 1'b0;
        id_mask = '0;
        live_count = 0;
        mismatches = 0;
        rx_hold = 1'b0;
        quiet_phase = 1'b0;
        stim_done = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty-table misses, extremes, every operation.
        dir_rows.push_back('{make_in(mht_pkg::MODE_LOOKUP_MAC, '0, '0, '0), 1, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_LOOKUP_ID, '0, 5'd31, '1), 1, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_DELETE, '1, 5'd0, '0), 1, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_INSERT, '1, 5'd31, '1), 1,
                             make_out(mht_pkg::ST_DONE, 5'd0, '1, '1)});
        dir_rows.push_back('{make_in(mht_pkg::MODE_INSERT, '0, '0, '0), 1,
                             make_out(mht_pkg::ST_DONE, 5'd1, '0, '0)});
        dir_rows.push_back('{make_in(mht_pkg::MODE_INSERT, '1, '0, 32'h1234), 1,
                             make_out(mht_pkg::ST_EXISTS, 5'd0, '1, '1)});
        dir_rows.push_back('{make_in(mht_pkg::MODE_LOOKUP_MAC, '0, '0, '1), 0, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_LOOKUP_ID, '1, 5'd1, '0), 0, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_LOOKUP_ID, '0, 5'd2, '0), 1, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_DELETE, '0, 5'd0, '0), 0, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_LOOKUP_MAC, '1, '0, '0), 1, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_INSERT, 48'hAAAA_5555_AAAA, '0,
                                     32'h5555_AAAA), 0, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_DELETE, '0, 5'd1, '0), 0, none});
        dir_rows.push_back('{make_in(mht_pkg::MODE_DELETE, '0, 5'd1, '0), 1, none});
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].check, dir_rows[i].want);
        wait_drained();

        // Fill the table past its ID limit; colliding keys come from random MACs.
        for (int i = 0; i < 36; i++)
            send_item(make_in(mht_pkg::MODE_INSERT, rand_mac(), '0, $urandom()), 0, none);
        // Delete every ID, exercising chain re-placement.
        for (int i = 31; i >= 0; i--)
            send_item(make_in(mht_pkg::MODE_DELETE, '0, i[mht_pkg::ID_W-1:0], '0), 0, none);
        wait_drained();

        // Receiver holds off while the sender keeps offering.
        rx_hold = 1'b1;
        for (int i = 0; i < 10; i++) send_item(rand_item(), 0, none);
        rx_hold = 1'b0;
        wait_drained();

        // Random part; the last stretch runs without idling.
        for (int i = 0; i < 1250; i++) begin
            if (i == 1100) quiet_phase = 1'b1;
            x = rand_item();
            // Refill after the table drains so the full case recurs.
            if (live_count < 8 && $urandom_range(0, 1) == 0) x.mode = mht_pkg::MODE_INSERT;
            send_item(x, 0, none);
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall bursts, plus a long hold-off when requested.
    initial begin
        int hold_cycles;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                hold_cycles = 0;
                i_out_ready <= 1'b0;
                while (hold_cycles < 300) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                while (rx_hold) begin
                    i_out_ready <= 1'b1;
                    @(posedge i_clk);
                end
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        mht_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result with no transaction pending: %h", o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected st=%0d id=%0d mac=%h own=%h",
                                 want.status, want.found_ident, want.found_mac,
                                 want.found_owner);
                        $display("          got      st=%0d id=%0d mac=%h own=%h",
                                 o_out_data.status, o_out_data.found_ident,
                                 o_out_data.found_mac, o_out_data.found_owner);
                    end
                end
            end
        end
    end

    // End of run.
    initial begin
        wait (stim_done);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #80ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/mht_pkg.sv
rtl/mht_ram.sv
rtl/mac_hash_table_with_id_slots.sv
rtl/mht_checker.sv
tb/sv/tb_top.sv
